// File: design/crps_pkg.sv
// Package for the clock ring pixel shader: types, constants and small helpers.
package crps_pkg;

    // LED counts of the two rings
    localparam int OUTER_LEDS_DEF = 60;
    localparam int INNER_LEDS_DEF = 24;

    // Field widths
    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int DAY_W   = 5;
    localparam int MS_W    = 32;
    localparam int POS_W   = 6;
    localparam int COLOR_W = 8;
    localparam int CFG_W   = 8;
    localparam int SPEED_W = 7;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_TWINKLE_LEVEL = 2'd0,
        CFG_TWINKLE_SPEED = 2'd1,
        CFG_MINUTE_TICKS  = 2'd2,
        CFG_HOUR_TICKS    = 2'd3
    } cfg_reg_t;

    localparam logic [7:0] LEVEL_RST = 8'd64;
    localparam logic [6:0] SPEED_RST = 7'd10;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV40,
        ST_DIVS,
        ST_LCG,
        ST_SCALE,
        ST_DONE
    } crps_state_t;

    // Twinkle generator
    localparam logic [31:0] LCG_MUL    = 32'd1664525;
    localparam logic [31:0] LCG_ADD    = 32'd1013904223;
    localparam logic [31:0] S_XOR      = 32'hA5A5_BEEF;
    localparam logic [31:0] SEED_XOR   = 32'h0000_1234;
    // millis / 40 as (millis >> 3) / 5; ceil(2^31/5), exact below 2^29
    localparam logic [28:0] DIV5_RECIP = 29'h1999_999A;
    localparam logic [6:0]  SPEED_SPAN = 7'd64;
    localparam logic [6:0]  OUTER_BR_BASE = 7'd16;
    localparam logic [6:0]  INNER_BR_BASE = 7'd12;
    localparam logic [7:0]  OUTER_BR_MASK = 8'h3F;
    localparam logic [7:0]  INNER_BR_MASK = 8'h33;

    // Colors
    localparam logic [7:0] BG_RED     = 8'(255 / 20);
    localparam logic [7:0] BG_GREEN   = 8'(197 / 20);
    localparam logic [7:0] BG_BLUE    = 8'(143 / 20);
    localparam logic [7:0] TICK_LEVEL = 8'd20;
    localparam logic [7:0] SEC_BLUE   = 8'd150;
    localparam logic [7:0] MIN_GREEN  = 8'd80;
    localparam logic [7:0] HOUR_RED   = 8'd140;
    localparam logic [7:0] WHITE_G    = 8'd200;
    localparam logic [7:0] WHITE_B    = 8'd160;

    // Reciprocals for small constant divisors: q = (v * ceil(2^16/d)) >> 16, exact for v < 256
    localparam logic [16:0] RECIP5  = 17'((65536 + 5 - 1) / 5);
    localparam logic [16:0] RECIP6  = 17'((65536 + 6 - 1) / 6);
    localparam logic [16:0] RECIP12 = 17'((65536 + 12 - 1) / 12);
    // ceil(2^24/255), exact for x < 65536
    localparam logic [16:0] RECIP255 = 17'(((1 << 24) + 255 - 1) / 255);

    // v mod d by reciprocal multiply; m = ceil(2^16/d), d <= 255
    function automatic logic [7:0] mod_small(input logic [7:0] v, input logic [7:0] d,
                                             input logic [16:0] m);
        logic [24:0] prod;
        logic [7:0]  q;
        logic [15:0] qd;
        prod = 25'(v) * 25'(m);
        q    = prod[23:16];
        qd   = 16'(q) * 16'(d);
        return v - qd[7:0];
    endfunction

    // x / 255 for x < 65536
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [32:0] prod;
        prod = 33'(x) * 33'(RECIP255);
        return prod[31:24];
    endfunction

endpackage

// File: design/crps_pixel_if.sv
// Input channel: one pixel query word with time fields and LED position.
interface crps_pixel_if;
    import crps_pkg::*;

    logic               valid;
    logic               ready;
    logic [SEC_W-1:0]   second;
    logic [MIN_W-1:0]   minute;
    logic [HOUR_W-1:0]  hour;
    logic [DAY_W-1:0]   day_of_month;
    logic [MS_W-1:0]    millis;
    logic               ring_select;
    logic [POS_W-1:0]   position;

    modport source (
        output valid, second, minute, hour, day_of_month, millis, ring_select, position,
        input  ready
    );
    modport sink (
        input  valid, second, minute, hour, day_of_month, millis, ring_select, position,
        output ready
    );
endinterface

// File: design/crps_color_if.sv
// Output channel: one RGB color word.
interface crps_color_if;
    import crps_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink (input valid, red, green, blue, output ready);
endinterface

// File: design/clock_ring_pixel_shader.sv
// Clock ring pixel shader: RGB color of one LED from time, position and twinkle settings.
//
// One query word in, one color word out. A word is taken only while the
// sequencer is idle. An off-ring position, or a twinkle level of zero, goes
// straight to the output state. Otherwise the word passes through millis / 40
// (reciprocal multiply), millis / speed divisor in a restoring divider, then
// one LCG step per cycle on one 32-bit multiplier for 2 * (outer + inner
// twinkle count) steps plus a drain of the last compare, then a scaling state
// and the output state, which holds while the last color is not yet taken.
// The result sits in an output register, so the next word is accepted while
// a color waits to be taken.
// Configuration writes are taken any cycle but are meant for idle periods.
module clock_ring_pixel_shader #(
    parameter int OUTER_LEDS = crps_pkg::OUTER_LEDS_DEF,
    parameter int INNER_LEDS = crps_pkg::INNER_LEDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    crps_pixel_if.sink                    pixel,
    crps_color_if.source                  color,
    input  logic                          wr_en,
    input  logic [1:0]                    wr_index,
    input  logic [crps_pkg::CFG_W-1:0]    wr_data
);
    import crps_pkg::*;

    localparam logic [7:0]  OUTER_N     = 8'(OUTER_LEDS);
    localparam logic [7:0]  INNER_N     = 8'(INNER_LEDS);
    localparam logic [16:0] OUTER_RECIP = 17'((65536 + OUTER_LEDS - 1) / OUTER_LEDS);
    localparam logic [16:0] INNER_RECIP = 17'((65536 + INNER_LEDS - 1) / INNER_LEDS);

    // ---------------- configuration ----------------
    logic [7:0]         level_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic               min_ticks_reg;
    logic               hour_ticks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg      <= LEVEL_RST;
            speed_reg      <= SPEED_RST;
            min_ticks_reg  <= 1'b1;
            hour_ticks_reg <= 1'b1;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_TWINKLE_LEVEL: level_reg      <= wr_data;
                CFG_TWINKLE_SPEED: speed_reg      <= wr_data[SPEED_W-1:0];
                CFG_MINUTE_TICKS:  min_ticks_reg  <= wr_data[0];
                CFG_HOUR_TICKS:    hour_ticks_reg <= wr_data[0];
                default:           ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    crps_state_t state_reg, state_next;

    logic       accept;
    logic       load_color;
    logic       div_run;
    logic [4:0] div_cnt_reg;
    logic [5:0] step_reg;
    logic [5:0] total_reg;
    logic       in_ok;

    // held query fields
    logic [SEC_W-1:0]  sec_reg;
    logic [MIN_W-1:0]  min_reg;
    logic [HOUR_W-1:0] hour_reg;
    logic [DAY_W-1:0]  day_reg;
    logic [MS_W-1:0]   ms_reg;
    logic              inner_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              pos_ok_reg;

    assign accept = pixel.valid && pixel.ready;

    // position is on the selected ring
    assign in_ok = pixel.ring_select ? (8'(pixel.position) < INNER_N)
                                     : (8'(pixel.position) < OUTER_N);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!in_ok || level_reg == 8'd0)
                        state_next = ST_DONE;
                    else
                        state_next = ST_DIV40;
                end
            end
            ST_DIV40: state_next = ST_DIVS;
            ST_DIVS:  if (div_cnt_reg == 5'd31) state_next = ST_LCG;
            ST_LCG:   if (step_reg == total_reg) state_next = ST_SCALE;
            ST_SCALE: state_next = ST_DONE;
            ST_DONE:  if (load_color) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pixel.ready = 1'b0;
        div_run     = 1'b0;
        load_color  = 1'b0;
        case (state_reg)
            ST_IDLE:  pixel.ready = 1'b1;
            ST_DIVS:  div_run     = 1'b1;
            ST_DONE:  load_color  = !color.valid || color.ready;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ---------------- millis / 40 ----------------
    // (millis >> 3) / 5 by reciprocal multiply, registered in the DIV40 state
    logic [57:0] q40_prod;

    assign q40_prod = 58'(ms_reg[31:3]) * 58'(DIV5_RECIP);

    // ---------------- restoring divider: millis / speed divisor ----------------
    // Quotient builds up in place of the dividend, one bit per cycle.
    logic [6:0]  rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] q40_reg;
    logic [6:0]  den;
    logic [7:0]  trial;
    logic        trial_ge;
    logic [6:0]  rem_step;
    logic [31:0] quo_step;

    assign den      = (speed_reg < SPEED_SPAN) ? (SPEED_SPAN - speed_reg) : 7'd1;
    assign trial    = {rem_reg, quo_reg[31]};
    assign trial_ge = trial >= {1'b0, den};
    assign rem_step = trial_ge ? 7'(trial - {1'b0, den}) : trial[6:0];
    assign quo_step = {quo_reg[30:0], trial_ge};

    // ---------------- LCG and twinkle compare ----------------
    logic [31:0] s_reg;
    logic [31:0] s_lcg;
    logic [31:0] seed;
    logic [5:0]  outer_end_reg;
    logic [5:0]  step_idx;
    logic        inner_phase;
    logic [7:0]  tw_pos;
    logic [6:0]  tw_br;
    logic        hit_reg;
    logic        tw_reg;
    logic [6:0]  br_reg;
    logic [4:0]  cnt_outer;
    logic [2:0]  cnt_inner;

    assign s_lcg = s_reg * LCG_MUL + LCG_ADD;
    assign seed  = (32'(day_reg) << 24) ^ (32'(hour_reg) << 16) ^ (q40_reg << 8) ^ SEED_XOR;

    // s_reg holds the state after step_reg steps; step step_reg-1 is judged here
    assign step_idx    = step_reg - 6'd1;
    assign inner_phase = step_idx >= outer_end_reg;
    assign tw_pos      = inner_phase ? mod_small(s_reg[31:24], INNER_N, INNER_RECIP)
                                     : mod_small(s_reg[31:24], OUTER_N, OUTER_RECIP);
    assign tw_br       = inner_phase ? INNER_BR_BASE + 7'(s_reg[31:24] & INNER_BR_MASK)
                                     : OUTER_BR_BASE + 7'(s_reg[31:24] & OUTER_BR_MASK);

    assign cnt_outer = 5'(level_reg[7:4]) + 5'd1;
    assign cnt_inner = (level_reg[7:5] == 3'd0) ? 3'd1 : level_reg[7:5];

    // ---------------- white scaling ----------------
    logic [7:0] wg_reg;
    logic [7:0] wb_reg;

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
            step_reg    <= '0;
        end
        else
        begin
            if (div_run)
                div_cnt_reg <= div_cnt_reg + 5'd1;
            if (accept)
                step_reg <= '0;
            else if (state_reg == ST_LCG && step_reg != total_reg)
                step_reg <= step_reg + 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sec_reg       <= pixel.second;
            min_reg       <= pixel.minute;
            hour_reg      <= pixel.hour;
            day_reg       <= pixel.day_of_month;
            ms_reg        <= pixel.millis;
            inner_reg     <= pixel.ring_select;
            pos_reg       <= pixel.position;
            pos_ok_reg    <= in_ok;
            tw_reg        <= 1'b0;
            hit_reg       <= 1'b0;
            rem_reg       <= '0;
            quo_reg       <= pixel.millis;
            outer_end_reg <= 6'({cnt_outer, 1'b0});
            total_reg     <= 6'({cnt_outer, 1'b0}) + 6'({cnt_inner, 1'b0});
        end
        else if (state_reg == ST_DIV40)
        begin
            q40_reg <= {5'd0, q40_prod[57:31]};
        end
        else if (div_run)
        begin
            if (div_cnt_reg == 5'd31)
                s_reg <= (seed + quo_step) ^ S_XOR;
            else
            begin
                rem_reg <= rem_step;
                quo_reg <= quo_step;
            end
        end
        else if (state_reg == ST_LCG)
        begin
            if (step_reg != total_reg)
                s_reg <= s_lcg;
            if (step_reg != 6'd0)
            begin
                if (!step_idx[0])
                    hit_reg <= (inner_reg == inner_phase) && (tw_pos == 8'(pos_reg));
                else if (hit_reg)
                begin
                    tw_reg <= 1'b1;
                    br_reg <= tw_br;
                end
            end
        end
        else if (state_reg == ST_SCALE)
        begin
            wg_reg <= div255(16'(br_reg) * 16'(WHITE_G));
            wb_reg <= div255(16'(br_reg) * 16'(WHITE_B));
        end
    end

    // ---------------- layer composition ----------------
    logic [7:0] hour12;
    logic [7:0] hour2;
    logic [7:0] hour_pos;
    logic [7:0] sec_pos;
    logic [7:0] min_pos;
    logic [7:0] r_mix;
    logic [7:0] g_mix;
    logic [7:0] b_mix;

    assign hour12   = mod_small(8'(hour_reg), 8'd12, RECIP12);
    assign hour2    = {hour12[6:0], 1'b0};
    assign hour_pos = (hour2 >= INNER_N) ? hour2 - INNER_N : hour2;
    assign sec_pos  = mod_small(8'(sec_reg), OUTER_N, OUTER_RECIP);
    assign min_pos  = mod_small(8'(min_reg), OUTER_N, OUTER_RECIP);

    always_comb
    begin
        r_mix = BG_RED;
        g_mix = BG_GREEN;
        b_mix = BG_BLUE;
        if (tw_reg)
        begin
            r_mix = 8'(br_reg);
            g_mix = wg_reg;
            b_mix = wb_reg;
        end
        if (!inner_reg)
        begin
            if (min_ticks_reg && mod_small(8'(pos_reg), 8'd5, RECIP5) == 8'd0)
            begin
                r_mix = TICK_LEVEL;
                g_mix = TICK_LEVEL;
                b_mix = TICK_LEVEL;
            end
            if (8'(pos_reg) == sec_pos)
            begin
                r_mix = 8'd0;
                g_mix = 8'd0;
                b_mix = SEC_BLUE;
            end
            if (8'(pos_reg) == min_pos)
            begin
                r_mix = 8'd0;
                g_mix = MIN_GREEN;
                b_mix = 8'd0;
            end
        end
        else
        begin
            if (hour_ticks_reg && mod_small(8'(pos_reg), 8'd6, RECIP6) == 8'd0)
            begin
                r_mix = TICK_LEVEL;
                g_mix = TICK_LEVEL;
                b_mix = TICK_LEVEL;
            end
            if (8'(pos_reg) == hour_pos)
            begin
                r_mix = HOUR_RED;
                g_mix = 8'd0;
                b_mix = 8'd0;
            end
        end
        if (!pos_ok_reg)
        begin
            r_mix = 8'd0;
            g_mix = 8'd0;
            b_mix = 8'd0;
        end
    end

    // ---------------- output register ----------------
    logic               color_valid_reg;
    logic [COLOR_W-1:0] red_reg;
    logic [COLOR_W-1:0] green_reg;
    logic [COLOR_W-1:0] blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            color_valid_reg <= 1'b0;
        else if (load_color)
            color_valid_reg <= 1'b1;
        else if (color.ready)
            color_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_color)
        begin
            red_reg   <= r_mix;
            green_reg <= g_mix;
            blue_reg  <= b_mix;
        end
    end

    assign color.valid = color_valid_reg;
    assign color.red   = red_reg;
    assign color.green = green_reg;
    assign color.blue  = blue_reg;

    // ---------------- assertions ----------------
    a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE)
        else $error("accepted word left the sequencer idle");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LCG |-> step_reg <= total_reg)
        else $error("LCG step count ran past its total");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIVS |-> rem_reg < den)
        else $error("divider remainder not below divisor");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load_color |=> color.valid && state_reg == ST_IDLE)
        else $error("finished color not presented");

endmodule

// File: bench/testbench.sv
// Testbench for the clock ring pixel shader: directed and random pixel queries checked against a color predictor.
module testbench;
    import crps_pkg::*;

    // Ring geometry, passed to the block so both sides agree
    localparam int OUTER_COUNT = 60;
    localparam int INNER_COUNT = 24;
    localparam bit OUTER_RING  = 1'b0;
    localparam bit INNER_RING  = 1'b1;

    // Run shape
    localparam int RANDOM_WORDS = 1650;
    localparam int PHASES       = 8;
    localparam int MAX_WAIT     = 12;
    // The tail outlasts one more longest pixel plus margin
    localparam int TAIL_CYCLES  = 150;
    // Slowest correct run: ~1700 words, each with the longest gap, busy time and stall, is ~1.8M
    // time units; stop well beyond that
    localparam int WATCHDOG     = 15_000_000;

    // Twinkle generator
    localparam logic [31:0] LCG_MULT  = 32'd1664525;
    localparam logic [31:0] LCG_INC   = 32'd1013904223;
    localparam logic [31:0] STATE_MIX = 32'hA5A5_BEEF;
    localparam logic [31:0] SEED_MIX  = 32'h0000_1234;
    localparam int          OUTER_BR_FLOOR = 16;
    localparam int          INNER_BR_FLOOR = 12;
    localparam logic [7:0]  OUTER_BR_BITS  = 8'h3F;
    localparam logic [7:0]  INNER_BR_BITS  = 8'h33;

    // Palette
    localparam logic [7:0] DIM_R   = 8'd12;
    localparam logic [7:0] DIM_G   = 8'd9;
    localparam logic [7:0] DIM_B   = 8'd7;
    localparam logic [7:0] TICK    = 8'd20;
    localparam logic [7:0] SEC_B   = 8'd150;
    localparam logic [7:0] MIN_G   = 8'd80;
    localparam logic [7:0] HOUR_R  = 8'd140;

    typedef struct packed {
        logic [SEC_W-1:0]  second;
        logic [MIN_W-1:0]  minute;
        logic [HOUR_W-1:0] hour;
        logic [DAY_W-1:0]  day_of_month;
        logic [MS_W-1:0]   millis;
        logic              ring_select;
        logic [POS_W-1:0]  position;
    } pixel_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } color_t;

    // Holds a copy of the registers, works out the color of each accepted
    // pixel and keeps the colors still owed by the block, oldest first.
    class color_scoreboard;
        logic [7:0] level;
        logic [6:0] speed;
        logic       minute_ticks;
        logic       hour_ticks;
        color_t     expected_colors[$];
        int         errors;

        function new();
            level        = 8'd64;
            speed        = 7'd10;
            minute_ticks = 1'b1;
            hour_ticks   = 1'b1;
            errors       = 0;
        endfunction

        // Mirrors the register widths: upper data bits are dropped
        function void set_reg(cfg_reg_t index, logic [CFG_W-1:0] data);
            case (index)
                CFG_TWINKLE_LEVEL: level = data;
                CFG_TWINKLE_SPEED: speed = data[6:0];
                CFG_MINUTE_TICKS:  minute_ticks = data[0];
                CFG_HOUR_TICKS:    hour_ticks = data[0];
                default: ;
            endcase
        endfunction

        function logic [31:0] lcg_step(logic [31:0] s);
            return s * LCG_MULT + LCG_INC;
        endfunction

        // Warm white at brightness br (red is br * 255 / 255)
        function color_t white(int unsigned br);
            color_t c;
            c.red   = COLOR_W'(br);
            c.green = COLOR_W'((200 * br) / 255);
            c.blue  = COLOR_W'((160 * br) / 255);
            return c;
        endfunction

        function color_t shade(pixel_t px);
            color_t      c;
            logic [31:0] seed;
            logic [31:0] s;
            int unsigned ring;
            int unsigned divisor;
            int unsigned outer_n;
            int unsigned inner_n;
            int unsigned p;
            ring = px.ring_select ? INNER_COUNT : OUTER_COUNT;
            if (px.position >= ring)
                return '0;
            c = {DIM_R, DIM_G, DIM_B};
            if (level != 0)
            begin
                divisor = (speed < 64) ? 64 - speed : 1;
                seed = (32'(px.day_of_month) << 24) ^ (32'(px.hour) << 16)
                     ^ ((px.millis / 32'd40) << 8) ^ SEED_MIX;
                s = (seed + px.millis / divisor) ^ STATE_MIX;
                outer_n = 1 + level / 16;
                inner_n = level / 32;
                if (inner_n < 1)
                    inner_n = 1;
                // outer twinkles run first; the inner ones continue the sequence
                repeat (outer_n)
                begin
                    s = lcg_step(s);
                    p = s[31:24] % OUTER_COUNT;
                    s = lcg_step(s);
                    if (!px.ring_select && p == px.position)
                        c = white(OUTER_BR_FLOOR + (s[31:24] & OUTER_BR_BITS));
                end
                repeat (inner_n)
                begin
                    s = lcg_step(s);
                    p = s[31:24] % INNER_COUNT;
                    s = lcg_step(s);
                    if (px.ring_select && p == px.position)
                        c = white(INNER_BR_FLOOR + (s[31:24] & INNER_BR_BITS));
                end
            end
            if (!px.ring_select)
            begin
                if (minute_ticks && px.position % 5 == 0)
                    c = {TICK, TICK, TICK};
                if (px.position == px.second % OUTER_COUNT)
                    c = {8'd0, 8'd0, SEC_B};
                if (px.position == px.minute % OUTER_COUNT)
                    c = {8'd0, MIN_G, 8'd0};
            end
            else
            begin
                if (hour_ticks && px.position % 6 == 0)
                    c = {TICK, TICK, TICK};
                if (px.position == ((px.hour % 12) * 2) % INNER_COUNT)
                    c = {HOUR_R, 8'd0, 8'd0};
            end
            return c;
        endfunction

        function void note_pixel(pixel_t px);
            expected_colors.push_back(shade(px));
        endfunction

        function void check_color(color_t got);
            color_t want;
            if (expected_colors.size() == 0)
            begin
                $error("color word with none expected: red %0d green %0d blue %0d",
                       got.red, got.green, got.blue);
                errors++;
                return;
            end
            want = expected_colors.pop_front();
            if (got.red !== want.red)
            begin
                $error("red: expected %0d, actual %0d", want.red, got.red);
                errors++;
            end
            if (got.green !== want.green)
            begin
                $error("green: expected %0d, actual %0d", want.green, got.green);
                errors++;
            end
            if (got.blue !== want.blue)
            begin
                $error("blue: expected %0d, actual %0d", want.blue, got.blue);
                errors++;
            end
        endfunction

        function int pending();
            return expected_colors.size();
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             wr_en;
    cfg_reg_t         wr_index;
    logic [CFG_W-1:0] wr_data;
    bit               calm;     // phase-wide: no idling on either side
    color_scoreboard  sb;

    crps_pixel_if pix();
    crps_color_if col();

    clock_ring_pixel_shader #(
        .OUTER_LEDS(OUTER_COUNT),
        .INNER_LEDS(INNER_COUNT)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel    (pix),
        .color    (col),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        #WATCHDOG;
        $display("** clock_ring_pixel_shader: FAILED **");
        $finish;
    end

    function automatic pixel_t query(int sec, int mnt, int hr, int day,
                                     logic [31:0] ms, bit ring, int pos);
        pixel_t w;
        w.second       = SEC_W'(sec);
        w.minute       = MIN_W'(mnt);
        w.hour         = HOUR_W'(hr);
        w.day_of_month = DAY_W'(day);
        w.millis       = ms;
        w.ring_select  = ring;
        w.position     = POS_W'(pos);
        return w;
    endfunction

    // Offer one pixel word after a random gap. Called at a rising edge and
    // returns at the edge that took the word, with valid still high so a
    // zero-gap successor follows back to back. Handshake is sampled on the
    // falling edge, where valid and ready are settled.
    task automatic send_word(pixel_t w);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix.valid        <= 1'b1;
        pix.second       <= w.second;
        pix.minute       <= w.minute;
        pix.hour         <= w.hour;
        pix.day_of_month <= w.day_of_month;
        pix.millis       <= w.millis;
        pix.ring_select  <= w.ring_select;
        pix.position     <= w.position;
        @(negedge clk);
        while (!pix.ready)
            @(negedge clk);
        @(posedge clk);
        sb.note_pixel(w);
    endtask

    // Drop valid and hold off until every owed color has come back.
    // The do-while loop always waits on the clock before returning, so valid
    // is never lowered and raised in the same step.
    task automatic drain_colors();
        pix.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // One register write; the block is idle whenever this is called
    task automatic write_reg(cfg_reg_t index, logic [CFG_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= index;
        wr_data  <= data;
        @(posedge clk);
        sb.set_reg(index, data);
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Color sink: random stall before each word, checks on acceptance
    initial
    begin : color_sink
        int     stall;
        color_t got;
        col.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                col.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            col.ready <= 1'b1;
            @(negedge clk);
            while (!col.valid)
                @(negedge clk);
            got = {col.red, col.green, col.blue};
            @(posedge clk);
            sb.check_color(got);
        end
    end

    initial
    begin : stimulus
        pixel_t     w;
        int         phase_words;
        int         ring;
        logic [7:0] lvl;
        logic [7:0] spd;
        logic [7:0] mt;
        logic [7:0] ht;
        sb   = new();
        calm = 1'b0;
        rst_n            <= 1'b0;
        wr_en            <= 1'b0;
        wr_index         <= CFG_TWINKLE_LEVEL;
        wr_data          <= '0;
        pix.valid        <= 1'b0;
        pix.second       <= '0;
        pix.minute       <= '0;
        pix.hour         <= '0;
        pix.day_of_month <= '0;
        pix.millis       <= '0;
        pix.ring_select  <= 1'b0;
        pix.position     <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // ---- directed words, registers at their reset values ----
        // minute hand beats second hand beats tick at the same LED
        send_word(query(0, 0, 3, 15, 32'd0, OUTER_RING, 0));
        send_word(query(5, 10, 3, 15, 32'd1000, OUTER_RING, 5));
        send_word(query(5, 10, 3, 15, 32'd1000, OUTER_RING, 10));
        // second 63 and minute 62 wrap around the outer ring
        send_word(query(63, 62, 3, 15, 32'd1000, OUTER_RING, 3));
        send_word(query(63, 62, 3, 15, 32'd1000, OUTER_RING, 2));
        send_word(query(63, 62, 3, 15, 32'd1000, OUTER_RING, 15));
        send_word(query(59, 58, 0, 1, 32'hFFFF_FFFF, OUTER_RING, 59));
        // LEDs past the end of either ring stay dark
        send_word(query(0, 0, 0, 31, 32'hFFFF_FFFF, OUTER_RING, 60));
        send_word(query(0, 0, 0, 31, 32'hFFFF_FFFF, OUTER_RING, 63));
        send_word(query(0, 0, 0, 31, 32'hFFFF_FFFF, INNER_RING, 24));
        send_word(query(0, 0, 0, 31, 32'hFFFF_FFFF, INNER_RING, 63));
        // hour hand: over a tick, hour 23, and out-of-range hour 31
        send_word(query(0, 0, 0, 0, 32'd0, INNER_RING, 0));
        send_word(query(0, 0, 23, 1, 32'd12345, INNER_RING, 22));
        send_word(query(0, 0, 31, 31, 32'hFFFF_FFFF, INNER_RING, 14));
        send_word(query(0, 0, 12, 5, 32'd777, INNER_RING, 6));
        send_word(query(0, 0, 12, 5, 32'd777, INNER_RING, 23));
        send_word(query(30, 45, 6, 20, 32'h8000_0000, OUTER_RING, 1));
        send_word(query(1, 2, 3, 4, 32'h7FFF_FFFF, OUTER_RING, 7));

        // twinkles off, then ticks off: only background and hands remain
        drain_colors();
        write_reg(CFG_TWINKLE_LEVEL, 8'd0);
        send_word(query(30, 45, 6, 20, 32'h8000_0000, OUTER_RING, 1));
        drain_colors();
        write_reg(CFG_MINUTE_TICKS, 8'h00);
        write_reg(CFG_HOUR_TICKS, 8'h02);
        send_word(query(30, 45, 6, 20, 32'd99, OUTER_RING, 5));
        send_word(query(30, 45, 6, 20, 32'd99, INNER_RING, 6));

        // ---- random phases, each under its own register setting ----
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_colors();
            // first phases pin the extremes: level 0/1/255 and the count
            // steps at 16 and 32, divisor 64, 1 (speed 63), held at 1 (64, 127)
            case (ph)
                0: begin lvl = 8'd255; spd = 8'd64;  mt = 8'h01; ht = 8'hFE; end
                1: begin lvl = 8'd1;   spd = 8'hFF;  mt = 8'hFE; ht = 8'h01; end
                2: begin lvl = 8'd0;   spd = 8'd0;   mt = 8'hFF; ht = 8'hFF; end
                3: begin lvl = 8'd16;  spd = 8'd63;  mt = 8'h00; ht = 8'h00; end
                4: begin lvl = 8'd32;  spd = 8'd0;   mt = 8'h01; ht = 8'h01; end
                5: begin lvl = 8'd31;  spd = 8'd127; mt = 8'h80; ht = 8'h7F; end
                default:
                begin
                    lvl = 8'($urandom_range(0, 255));
                    spd = 8'($urandom_range(0, 255));
                    mt  = 8'($urandom_range(0, 255));
                    ht  = 8'($urandom_range(0, 255));
                end
            endcase
            write_reg(CFG_TWINKLE_LEVEL, lvl);
            write_reg(CFG_TWINKLE_SPEED, spd);
            write_reg(CFG_MINUTE_TICKS, mt);
            write_reg(CFG_HOUR_TICKS, ht);
            calm = (ph == 3) || ($urandom_range(0, 4) == 0);

            phase_words = 0;
            while (phase_words < RANDOM_WORDS / PHASES)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    // a whole frame: one time, every LED of one ring in turn,
                    // so each twinkle of that frame gets hit
                    w.second       = SEC_W'($urandom_range(0, 59));
                    w.minute       = MIN_W'($urandom_range(0, 59));
                    w.hour         = HOUR_W'($urandom_range(0, 23));
                    w.day_of_month = DAY_W'($urandom_range(1, 31));
                    w.millis       = $urandom();
                    w.ring_select  = 1'($urandom_range(0, 1));
                    ring = w.ring_select ? INNER_COUNT : OUTER_COUNT;
                    for (int p = 0; p < ring; p++)
                    begin
                        w.position = POS_W'(p);
                        send_word(w);
                    end
                    phase_words += ring;
                end
                else
                begin
                    // burst of unrelated words over the full field ranges,
                    // off-ring positions and out-of-range times included
                    repeat (10)
                    begin
                        w.second       = SEC_W'($urandom_range(0, 63));
                        w.minute       = MIN_W'($urandom_range(0, 63));
                        w.hour         = HOUR_W'($urandom_range(0, 31));
                        w.day_of_month = DAY_W'($urandom_range(0, 31));
                        w.millis       = $urandom();
                        w.ring_select  = 1'($urandom_range(0, 1));
                        w.position     = POS_W'($urandom_range(0, 63));
                        send_word(w);
                    end
                    phase_words += 10;
                end
            end
        end

        // wait out everything owed, then watch for stray color words
        drain_colors();
        calm = 1'b0;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("** clock_ring_pixel_shader: PASSED **");
        else
            $display("** clock_ring_pixel_shader: FAILED **");
        $finish;
    end

endmodule
